### rtl/core/lzm_pkg.sv
// ============================================================================
// lzm_pkg: shared types and constants of the layer z-order manager
// Request codes, sequencer states, stream widths and default sizes.
// ============================================================================
package lzm_pkg;

  localparam int DEF_NUM_LAYERS = 32;
  localparam int DEF_COORD_BITS = 12;

  // Layers examined per cycle by the free-layer search.
  localparam int SCAN_W = 8;

  localparam int REQ_W      = 3;
  localparam int LID_W      = 5;
  localparam int IN_W       = 12;
  localparam int RECT_W     = 13;
  localparam int S_TDATA_W  = 64;
  localparam int M_TDATA_W  = 64;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_RECT   = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC      = 3'd0,
    REQ_SET_SIZE   = 3'd1,
    REQ_MOVE       = 3'd2,
    REQ_SET_HEIGHT = 3'd3,
    REQ_FREE       = 3'd4,
    REQ_REFRESH    = 3'd5
  } req_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DEC,
    S_MV_OLD,
    S_MV_NEW,
    S_RF_RECT,
    S_SH_INIT,
    S_SH_RD,
    S_SH_WR,
    S_SH_FIN,
    S_SH_RECT,
    S_STATUS
  } state_e;

endpackage

### rtl/core/lzm_free_scan.sv
// ============================================================================
// lzm_free_scan: free-layer search over one group of layers
// Finds the lowest unused layer within the group selected by chunk_i.
// ============================================================================
module lzm_free_scan #(
  parameter int NUM_LAYERS = lzm_pkg::DEF_NUM_LAYERS
) (
  input  logic [NUM_LAYERS-1:0]                            in_use_i,
  input  logic [((NUM_LAYERS + lzm_pkg::SCAN_W - 1) / lzm_pkg::SCAN_W > 1 ?
                 $clog2((NUM_LAYERS + lzm_pkg::SCAN_W - 1) / lzm_pkg::SCAN_W) :
                 1) - 1:0]                                 chunk_i,
  output logic                                             found_o,
  output logic [$clog2(NUM_LAYERS)-1:0]                    idx_o
);
  import lzm_pkg::*;

  localparam int IDW = $clog2(NUM_LAYERS);
  localparam int NCH = (NUM_LAYERS + SCAN_W - 1) / SCAN_W;
  localparam int IXW = $clog2(NCH * SCAN_W);

  always_comb begin
    logic [IXW-1:0] cand;
    logic           free;
    found_o = 1'b0;
    idx_o   = '0;
    for (int j = SCAN_W - 1; j >= 0; j--) begin
      cand = IXW'(IXW'(chunk_i) * IXW'(SCAN_W)) + IXW'(j);
      free = (int'(cand) < NUM_LAYERS) && !in_use_i[cand[IDW-1:0]];
      if (free) begin
        found_o = 1'b1;
        idx_o   = cand[IDW-1:0];
      end
    end
  end

endmodule

### rtl/core/layer_zorder_manager.sv
// ============================================================================
// layer_zorder_manager: display layer pool and stacking-order table
// Allocates, sizes, moves, restacks, frees and refreshes layers, and reports
// the screen rectangles to repaint followed by one status item per request.
// ============================================================================
// Requests enter on the slave stream (tuser carries the request type) and
// each one produces up to two rectangle items and always ends with a status
// item, marked by tlast. tuser on the master stream is 0 for status and 1 for
// a rectangle. One request is worked on at a time; s_tready_o is high only
// between requests.
// Alloc searches the layers one group of 8 at a time. Set height and free
// shift order-table entries when the height changes, as each shift reads the
// order-table memory and then writes it back; an unchanged height skips the
// shift, and freeing a hidden layer goes straight to the status item.
// Results sit in an output register; while the receiver stalls the sequencer
// waits in the emitting state and no item is lost.
// After reset all layers are free and hidden, sizes and positions read as
// zero, and the order table is empty. No clearing pass is needed.
// ============================================================================
module layer_zorder_manager #(
  parameter int NUM_LAYERS = lzm_pkg::DEF_NUM_LAYERS,
  parameter int COORD_BITS = lzm_pkg::DEF_COORD_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_tvalid_i,
  output logic                             s_tready_o,
  // layer[4:0], height_req[12:5], a_x[24:13], a_y[36:25], b_x[48:37],
  // b_y[60:49], zero fill above.
  input  logic [lzm_pkg::S_TDATA_W-1:0]    s_tdata_i,
  // req_type[2:0].
  input  logic [lzm_pkg::REQ_W-1:0]        s_tuser_i,
  output logic                             m_tvalid_o,
  input  logic                             m_tready_i,
  // ok[0], layer_id[5:1], rect_x0[18:6], rect_y0[31:19], rect_x1[44:32],
  // rect_y1[57:45], zero fill above.
  output logic [lzm_pkg::M_TDATA_W-1:0]    m_tdata_o,
  // kind[0].
  output logic                             m_tuser_o,
  output logic                             m_tlast_o
);
  import lzm_pkg::*;

  localparam int IDW    = $clog2(NUM_LAYERS);
  localparam int HW     = IDW + 1;
  localparam int CW     = ((HW > 8) ? HW : 8) + 1;
  localparam int SW     = ((COORD_BITS > IN_W) ? COORD_BITS : IN_W) + 1;
  localparam int ZW     = COORD_BITS - 1;
  localparam int SZ_MAX = (1 << ZW) - 1;
  localparam int NCH    = (NUM_LAYERS + SCAN_W - 1) / SCAN_W;
  localparam int CHW    = (NCH > 1) ? $clog2(NCH) : 1;

  state_e state_q, state_d;

  logic [REQ_W-1:0]        req_q;
  logic [LID_W-1:0]        lf_q;
  logic signed [7:0]       tgt_q, tgt_d;
  logic signed [IN_W-1:0]  ax_q, ay_q, bx_q, by_q;

  logic signed [HW-1:0]    top_q, top_d;
  logic [NUM_LAYERS-1:0]   in_use_q, in_use_d;
  logic [NUM_LAYERS-1:0]   hvld_q, pvld_q, svld_q;

  logic signed [HW-1:0]    hgt_mem [NUM_LAYERS];
  logic [IDW-1:0]          ord_mem [NUM_LAYERS];
  logic [2*COORD_BITS-1:0] pos_mem [NUM_LAYERS];
  logic [2*ZW-1:0]         siz_mem [NUM_LAYERS];

  logic signed [HW-1:0]    hgt_rd_q;
  logic [IDW-1:0]          ord_rd_q;
  logic [2*COORD_BITS-1:0] pos_rd_q;
  logic [2*ZW-1:0]         siz_rd_q;
  logic                    hvld_rd_q, pvld_rd_q, svld_rd_q;

  logic [CHW-1:0]          c_q, c_d;
  logic signed [HW-1:0]    old_q, old_d, h_q, h_d, w_q, w_d, e_q, e_d;
  logic                    up_q, up_d, ins_q, ins_d, tinc_q, tinc_d, tdec_q, tdec_d;
  logic signed [COORD_BITS-1:0] px_q, px_d, py_q, py_d;
  logic [ZW-1:0]           sw_q, sw_d, sh_q, sh_d;
  logic                    st_ok_q, st_ok_d;
  logic [LID_W-1:0]        st_id_q, st_id_d;

  logic                    m_tvalid_q, m_tvalid_d;
  logic [M_TDATA_W-1:0]    m_tdata_q, m_tdata_d;
  logic                    m_tuser_q, m_tuser_d, m_tlast_q, m_tlast_d;

  logic                    hw_en, ow_en, pw_en, zw_en, rd_en, or_en;
  logic [IDW-1:0]          hw_addr, ow_addr, or_addr;
  logic signed [HW-1:0]    hw_data;
  logic [IDW-1:0]          ow_data;

  logic                    in_acc, slot_free, lf_in, out_load, cont;
  logic [IDW-1:0]          id;
  logic signed [HW-1:0]    old_c, h_c, w_nx, w_rd;
  logic signed [CW-1:0]    tg_c, lm_c, hx_c;
  logic signed [COORD_BITS-1:0] npx, npy;
  logic [ZW-1:0]           nsw, nsh;
  logic signed [SW-1:0]    px_e, py_e, opa_x, opa_y, opb_x, opb_y;
  logic signed [RECT_W-1:0] rx0, ry0, rx1, ry1;
  logic                    scan_found;
  logic [IDW-1:0]          scan_idx;

  lzm_free_scan #(
    .NUM_LAYERS (NUM_LAYERS)
  ) u_scan (
    .in_use_i (in_use_q),
    .chunk_i  (c_q),
    .found_o  (scan_found),
    .idx_o    (scan_idx)
  );

  assign s_tready_o = (state_q == S_IDLE);
  assign in_acc     = s_tvalid_i && s_tready_o;
  assign slot_free  = !m_tvalid_q || m_tready_i;
  assign lf_in      = int'(lf_q) < NUM_LAYERS;
  assign id         = IDW'(lf_q);
  assign old_c      = hvld_rd_q ? hgt_rd_q : '1;

  assign npx = COORD_BITS'(ax_q);
  assign npy = COORD_BITS'(ay_q);
  assign nsw = (ax_q < 0) ? '0 : (int'(ax_q) > SZ_MAX) ? ZW'(SZ_MAX) : ZW'(ax_q);
  assign nsh = (ay_q < 0) ? '0 : (int'(ay_q) > SZ_MAX) ? ZW'(SZ_MAX) : ZW'(ay_q);

  // A hidden layer may go one above the current top, a visible one may not.
  assign tg_c = CW'(tgt_q);
  assign lm_c = old_q[HW-1] ? CW'(top_q) + CW'(1) : CW'(top_q);
  assign hx_c = (tg_c > lm_c) ? lm_c : (tg_c < CW'(-1)) ? CW'(-1) : tg_c;
  assign h_c  = HW'(hx_c);

  assign cont = up_q ? (w_q < e_q) : (w_q > e_q);
  assign w_rd = up_q ? w_q + HW'(1) : w_q - HW'(1);
  assign w_nx = w_rd;

  assign px_e  = SW'(px_q);
  assign py_e  = SW'(py_q);
  assign opa_x = (state_q == S_RF_RECT) ? SW'(ax_q) : '0;
  assign opa_y = (state_q == S_RF_RECT) ? SW'(ay_q) : '0;
  assign opb_x = (state_q == S_RF_RECT) ? SW'(bx_q) : SW'($signed({1'b0, sw_q}));
  assign opb_y = (state_q == S_RF_RECT) ? SW'(by_q) : SW'($signed({1'b0, sh_q}));
  assign rx0   = RECT_W'(px_e + opa_x);
  assign ry0   = RECT_W'(py_e + opa_y);
  assign rx1   = RECT_W'(px_e + opb_x);
  assign ry1   = RECT_W'(py_e + opb_y);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (req_q == REQ_ALLOC) begin
          state_d = S_SCAN;
        end else if (req_q > REQ_REFRESH || !lf_in) begin
          state_d = S_STATUS;
        end else if (req_q == REQ_SET_SIZE) begin
          state_d = S_STATUS;
        end else if (req_q == REQ_SET_HEIGHT && !in_use_q[id]) begin
          state_d = S_STATUS;
        end else begin
          state_d = S_DEC;
        end
      end
      S_SCAN: begin
        if (scan_found || c_q == CHW'(NCH - 1)) state_d = S_STATUS;
      end
      S_DEC: begin
        case (req_q)
          REQ_MOVE:       state_d = old_c[HW-1] ? S_STATUS : S_MV_OLD;
          REQ_SET_HEIGHT: state_d = S_SH_INIT;
          REQ_FREE:       state_d = old_c[HW-1] ? S_STATUS : S_SH_INIT;
          REQ_REFRESH:    state_d = old_c[HW-1] ? S_STATUS : S_RF_RECT;
          default:        state_d = S_STATUS;
        endcase
      end
      S_MV_OLD: begin
        if (slot_free) state_d = S_MV_NEW;
      end
      S_MV_NEW, S_RF_RECT, S_SH_RECT: begin
        if (slot_free) state_d = S_STATUS;
      end
      S_SH_INIT: begin
        state_d = (old_q == h_c) ? S_STATUS : S_SH_RD;
      end
      S_SH_RD: begin
        state_d = cont ? S_SH_WR : S_SH_FIN;
      end
      S_SH_WR: begin
        state_d = S_SH_RD;
      end
      S_SH_FIN: begin
        state_d = S_SH_RECT;
      end
      S_STATUS: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    tgt_d    = tgt_q;
    top_d    = top_q;
    in_use_d = in_use_q;
    c_d      = c_q;
    old_d    = old_q;
    h_d      = h_q;
    w_d      = w_q;
    e_d      = e_q;
    up_d     = up_q;
    ins_d    = ins_q;
    tinc_d   = tinc_q;
    tdec_d   = tdec_q;
    px_d     = px_q;
    py_d     = py_q;
    sw_d     = sw_q;
    sh_d     = sh_q;
    st_ok_d  = st_ok_q;
    st_id_d  = st_id_q;
    hw_en    = 1'b0;
    hw_addr  = id;
    hw_data  = h_c;
    ow_en    = 1'b0;
    ow_addr  = w_q[IDW-1:0];
    ow_data  = ord_rd_q;
    pw_en    = 1'b0;
    zw_en    = 1'b0;
    rd_en    = 1'b0;
    or_en    = 1'b0;
    or_addr  = w_rd[IDW-1:0];
    out_load = 1'b0;
    m_tuser_d  = KIND_RECT;
    m_tlast_d  = 1'b0;
    m_tdata_d  = M_TDATA_W'({ry1, rx1, ry0, rx0, lf_q, 1'b1});
    m_tvalid_d = m_tvalid_q && !m_tready_i;

    case (state_q)
      S_IDLE: begin
        if (in_acc) tgt_d = s_tdata_i[12:5];
      end
      S_CHECK: begin
        c_d     = '0;
        st_ok_d = 1'b1;
        st_id_d = lf_q;
        if (req_q == REQ_ALLOC) begin
          st_ok_d = 1'b1;
        end else if (req_q > REQ_REFRESH || !lf_in) begin
          st_ok_d = 1'b0;
        end else if (req_q == REQ_SET_SIZE) begin
          zw_en = 1'b1;
        end else if (req_q == REQ_SET_HEIGHT && !in_use_q[id]) begin
          st_ok_d = 1'b0;
        end else begin
          rd_en = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_found) begin
          in_use_d[scan_idx] = 1'b1;
          hw_en   = 1'b1;
          hw_addr = scan_idx;
          hw_data = '1;
          st_ok_d = 1'b1;
          st_id_d = LID_W'(scan_idx);
        end else if (c_q == CHW'(NCH - 1)) begin
          st_ok_d = 1'b0;
          st_id_d = '0;
        end else begin
          c_d = c_q + CHW'(1);
        end
      end
      S_DEC: begin
        old_d = old_c;
        px_d  = pvld_rd_q ? pos_rd_q[COORD_BITS-1:0] : '0;
        py_d  = pvld_rd_q ? pos_rd_q[2*COORD_BITS-1:COORD_BITS] : '0;
        sw_d  = svld_rd_q ? siz_rd_q[ZW-1:0] : '0;
        sh_d  = svld_rd_q ? siz_rd_q[2*ZW-1:ZW] : '0;
        if (req_q == REQ_FREE) tgt_d = '1;
        if (req_q == REQ_MOVE && old_c[HW-1]) pw_en = 1'b1;
      end
      S_MV_OLD: begin
        if (slot_free) begin
          out_load = 1'b1;
          pw_en    = 1'b1;
          px_d     = npx;
          py_d     = npy;
        end
      end
      S_MV_NEW, S_RF_RECT, S_SH_RECT: begin
        out_load = slot_free;
      end
      S_SH_INIT: begin
        hw_en  = 1'b1;
        h_d    = h_c;
        tinc_d = 1'b0;
        tdec_d = 1'b0;
        ins_d  = 1'b1;
        if (old_q > h_c) begin
          if (!h_c[HW-1]) begin
            up_d = 1'b0;
            w_d  = old_q;
            e_d  = h_c;
          end else begin
            up_d   = 1'b1;
            w_d    = old_q;
            e_d    = top_q;
            ins_d  = 1'b0;
            tdec_d = 1'b1;
          end
        end else if (!old_q[HW-1]) begin
          up_d = 1'b1;
          w_d  = old_q;
          e_d  = h_c;
        end else begin
          up_d   = 1'b0;
          w_d    = top_q + HW'(1);
          e_d    = h_c;
          tinc_d = 1'b1;
        end
      end
      S_SH_RD: begin
        or_en = cont;
      end
      S_SH_WR: begin
        ow_en   = 1'b1;
        hw_en   = 1'b1;
        hw_addr = ord_rd_q;
        hw_data = w_q;
        w_d     = w_nx;
      end
      S_SH_FIN: begin
        ow_en   = ins_q;
        ow_addr = h_q[IDW-1:0];
        ow_data = id;
        if (tinc_q) top_d = top_q + HW'(1);
        if (tdec_q) top_d = top_q - HW'(1);
      end
      S_STATUS: begin
        if (slot_free) begin
          out_load  = 1'b1;
          m_tuser_d = KIND_STATUS;
          m_tlast_d = 1'b1;
          m_tdata_d = M_TDATA_W'({st_id_q, st_ok_q});
          if (req_q == REQ_FREE && st_ok_q) in_use_d[id] = 1'b0;
        end
      end
      default: ;
    endcase

    if (out_load) m_tvalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      top_q      <= '1;
      in_use_q   <= '0;
      hvld_q     <= '0;
      pvld_q     <= '0;
      svld_q     <= '0;
      m_tvalid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      top_q      <= top_d;
      in_use_q   <= in_use_d;
      m_tvalid_q <= m_tvalid_d;
      if (hw_en) hvld_q[hw_addr] <= 1'b1;
      if (pw_en) pvld_q[id] <= 1'b1;
      if (zw_en) svld_q[id] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= s_tuser_i;
      lf_q  <= s_tdata_i[4:0];
      ax_q  <= s_tdata_i[24:13];
      ay_q  <= s_tdata_i[36:25];
      bx_q  <= s_tdata_i[48:37];
      by_q  <= s_tdata_i[60:49];
    end
    tgt_q   <= tgt_d;
    c_q     <= c_d;
    old_q   <= old_d;
    h_q     <= h_d;
    w_q     <= w_d;
    e_q     <= e_d;
    up_q    <= up_d;
    ins_q   <= ins_d;
    tinc_q  <= tinc_d;
    tdec_q  <= tdec_d;
    px_q    <= px_d;
    py_q    <= py_d;
    sw_q    <= sw_d;
    sh_q    <= sh_d;
    st_ok_q <= st_ok_d;
    st_id_q <= st_id_d;
    if (out_load) begin
      m_tdata_q <= m_tdata_d;
      m_tuser_q <= m_tuser_d;
      m_tlast_q <= m_tlast_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hw_en) hgt_mem[hw_addr] <= hw_data;
    if (ow_en) ord_mem[ow_addr] <= ow_data;
    if (pw_en) pos_mem[id] <= {npy, npx};
    if (zw_en) siz_mem[id] <= {nsh, nsw};
    if (rd_en) begin
      hgt_rd_q  <= hgt_mem[id];
      pos_rd_q  <= pos_mem[id];
      siz_rd_q  <= siz_mem[id];
      hvld_rd_q <= hvld_q[id];
      pvld_rd_q <= pvld_q[id];
      svld_rd_q <= svld_q[id];
    end
    if (or_en) ord_rd_q <= ord_mem[or_addr];
  end

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = m_tdata_q;
  assign m_tuser_o  = m_tuser_q;
  assign m_tlast_o  = m_tlast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o) |=> (state_q == S_CHECK))
    else $error("accepted item did not start the request check");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SH_WR) |-> ($past(state_q) == S_SH_RD))
    else $error("order-table write without a preceding read");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && scan_found) |=> in_use_q[$past(scan_idx)])
    else $error("allocated layer not marked as used");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (int'(top_q) < NUM_LAYERS && int'(top_q) >= -1))
    else $error("top height out of range between requests");

endmodule
